// ----- sv/sdel_pkg.sv -----
package sdel_pkg;

  // Default number of words the stack holds
  localparam int unsigned STACK_DEPTH_DEF = 16;

  // Field widths
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  // Stream payload widths (padded to whole bytes)
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 40;

  // Commands
  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

endpackage

// ----- sv/sdel_ram.sv -----
module sdel_ram import sdel_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
  localparam int unsigned AW = $clog2(STACK_DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [WORD_W-1:0] rdata_o
);

  logic [WORD_W-1:0] mem [STACK_DEPTH];
  logic [WORD_W-1:0] rdata_q;

  // Write one word per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read one word per cycle, registered
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/stack_with_delete_by_value_core.sv -----
// Channel   Dir  tdata (low bit up)                    tuser
// s_axis    in   operand_value[31:0]                   cmd[1:0]
// m_axis    out  result_value[31:0], occupancy[36:32]  status[1:0]
//
// Push, pop and peek run in S_EXEC after the accepting cycle. Delete scans
// one stored word per cycle through the single read port of the store, from
// the top down; on a match below the top, S_SHIFT_RD and then S_SHIFT_WR move
// each word above it down by one, and a miss ends at the bottom word.
// Input is taken only while the sequencer is idle; a result waits in the
// output register, and while m_axis stalls the next result waits in S_DONE,
// which also holds back new input.
// Reset empties the stack at once; the store needs no clearing pass.
module stack_with_delete_by_value_core import sdel_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // operand_value[31:0]
  input  logic [CMD_W-1:0]       s_axis_tuser_i,  // cmd[1:0]
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,  // result_value[31:0], occupancy[36:32]
  output logic [STATUS_W-1:0]    m_axis_tuser_o   // status[1:0]
);

  localparam int unsigned AW    = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SEARCH,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_e;

  state_e                  state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [AW-1:0]           addr_q, addr_d;
  cmd_e                    cmd_q;
  logic [WORD_W-1:0]       opnd_q;
  logic [WORD_W-1:0]       pend_value_q;
  status_e                 pend_status_q;
  logic [OCC_W-1:0]        pend_occ_q;
  logic                    out_valid_q;
  logic [OUT_TDATA_W-1:0]  out_data_q;
  logic [STATUS_W-1:0]     out_user_q;

  logic                    in_accept;
  logic                    out_free;
  logic                    fin;
  logic [WORD_W-1:0]       fin_value;
  status_e                 fin_status;
  logic [OCC_W-1:0]        fin_occ;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [WORD_W-1:0]       mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic [WORD_W-1:0]       mem_rdata;
  logic [CNT_W-1:0]        top_c;
  logic [CNT_W-1:0]        addr_p1_c;
  logic [CNT_W-1:0]        addr_p2_c;
  logic                    is_empty;
  logic                    is_full;
  logic                    word_match;

  assign in_accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free   = !out_valid_q || m_axis_tready_i;
  assign top_c      = count_q - 1'b1;
  assign addr_p1_c  = CNT_W'(addr_q) + 1'b1;
  assign addr_p2_c  = CNT_W'(addr_q) + CNT_W'(2);
  assign is_empty   = (count_q == '0);
  assign is_full    = (count_q == CNT_W'(STACK_DEPTH));
  // Comparator for the search
  assign word_match = (mem_rdata == opnd_q);

  sdel_ram #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Sequence one command: decide, search, shift, report
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    addr_d     = addr_q;
    fin        = 1'b0;
    fin_value  = '0;
    fin_status = STAT_OK;
    mem_we     = 1'b0;
    mem_waddr  = count_q[AW-1:0];
    mem_wdata  = opnd_q;
    mem_raddr  = top_c[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        unique case (cmd_q)
          CMD_PUSH: begin
            fin = 1'b1;
            if (is_full) begin
              fin_status = STAT_FULL;
            end else begin
              mem_we  = 1'b1;
              count_d = count_q + 1'b1;
            end
          end
          CMD_POP: begin
            fin = 1'b1;
            if (is_empty) begin
              fin_value  = '1;
              fin_status = STAT_EMPTY;
            end else begin
              fin_value = mem_rdata;
              count_d   = top_c;
            end
          end
          CMD_PEEK: begin
            fin = 1'b1;
            if (is_empty) begin
              fin_value  = '1;
              fin_status = STAT_EMPTY;
            end else begin
              fin_value = mem_rdata;
            end
          end
          CMD_DELETE: begin
            if (is_empty) begin
              fin        = 1'b1;
              fin_status = STAT_EMPTY;
            end else begin
              addr_d  = top_c[AW-1:0];
              state_d = S_SEARCH;
            end
          end
          default: ;
        endcase
      end
      S_SEARCH: begin
        // read data holds the word at addr_q; fetch the one below
        mem_raddr = addr_q - 1'b1;
        if (word_match) begin
          if (addr_p1_c == count_q) begin
            fin     = 1'b1;
            count_d = top_c;
          end else begin
            state_d = S_SHIFT_RD;
          end
        end else if (addr_q == '0) begin
          fin        = 1'b1;
          fin_status = STAT_NOT_FOUND;
        end else begin
          addr_d = addr_q - 1'b1;
        end
      end
      S_SHIFT_RD: begin
        mem_raddr = addr_p1_c[AW-1:0];
        state_d   = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        // move the word above down into the gap, prefetch the next one
        mem_we    = 1'b1;
        mem_waddr = addr_q;
        mem_wdata = mem_rdata;
        mem_raddr = addr_p2_c[AW-1:0];
        addr_d    = addr_p1_c[AW-1:0];
        if (addr_p2_c == count_q) begin
          fin     = 1'b1;
          count_d = top_c;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      state_d = out_free ? S_IDLE : S_DONE;
    end
  end

  assign fin_occ = OCC_W'(count_d);

  // Hold state, operands, the waiting result and the output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      count_q       <= '0;
      addr_q        <= '0;
      cmd_q         <= CMD_PUSH;
      opnd_q        <= '0;
      pend_value_q  <= '0;
      pend_status_q <= STAT_OK;
      pend_occ_q    <= '0;
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
      out_user_q    <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      addr_q  <= addr_d;
      if (in_accept) begin
        cmd_q  <= cmd_e'(s_axis_tuser_i);
        opnd_q <= s_axis_tdata_i[WORD_W-1:0];
      end
      if (fin && out_free) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {(OUT_TDATA_W - WORD_W - OCC_W)'(0), fin_occ, fin_value};
        out_user_q  <= fin_status;
      end else if (state_q == S_DONE && out_free) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {(OUT_TDATA_W - WORD_W - OCC_W)'(0), pend_occ_q, pend_value_q};
        out_user_q  <= pend_status_q;
      end else begin
        if (fin) begin
          pend_value_q  <= fin_value;
          pend_status_q <= fin_status;
          pend_occ_q    <= fin_occ;
        end
        // drop the word once taken
        if (out_valid_q && m_axis_tready_i) begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

// ----- sv/sdel_checker.sv -----
module sdel_checker import sdel_pkg::*; #(
  parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic [CMD_W-1:0]       s_axis_tuser_i,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input logic [STATUS_W-1:0]    m_axis_tuser_o
);

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result word changed while stalled");

  // One command at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken while a command is in work");

  // A refused push reports a full stack and a zero word
  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == STAT_FULL) |->
      (m_axis_tdata_o[31:0] == 32'd0) &&
      (m_axis_tdata_o[36:32] == OCC_W'(STACK_DEPTH)))
    else $error("full status with wrong word or occupancy");

  // An empty result reports no words and either all ones or zero
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == STAT_EMPTY) |->
      (m_axis_tdata_o[36:32] == 5'd0) &&
      ((m_axis_tdata_o[31:0] == 32'd0) || (m_axis_tdata_o[31:0] == 32'hFFFF_FFFF)))
    else $error("empty status with wrong word or occupancy");

endmodule

bind stack_with_delete_by_value_core sdel_checker #(
  .STACK_DEPTH(STACK_DEPTH)
) u_sdel_checker (.*);

// ----- tb/sv/tb_stack_with_delete_by_value_core.sv -----
module tb_stack_with_delete_by_value_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sdel_pkg::*;

  localparam int unsigned POOL_SIZE  = 12;
  localparam int unsigned TAIL_WAIT  = 40;   // longer than the slowest delete
  localparam int unsigned RAND_CMDS  = 366;  // per idling phase

  // Command word going into the stack and the reply expected back
  typedef struct {
    cmd_e             cmd;
    logic [WORD_W-1:0] operand;
  } stack_cmd_t;

  typedef struct {
    logic [WORD_W-1:0] value;
    status_e           status;
    logic [OCC_W-1:0]  occ;
  } stack_reply_t;

  // Words pushed by the directed fill; 5 appears twice on purpose
  localparam logic [WORD_W-1:0] FILL_WORDS [0:15] = '{
    32'h8000_0000, 32'h0000_0005, 32'h7fff_ffff, 32'hffff_ffff,
    32'h0000_0000, 32'h0000_0001, 32'haaaa_aaaa, 32'h5555_5555,
    32'h0000_0005, 32'h0000_ffff, 32'hffff_0000, 32'h1234_5678,
    32'hffff_fffe, 32'h4000_0000, 32'h0000_0003, 32'h0000_002a
  };

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;  // operand_value[31:0]
  logic [CMD_W-1:0]       s_axis_tuser_i  = '0;  // cmd[1:0]
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;  // result_value[31:0], occupancy[36:32]
  logic [STATUS_W-1:0]    m_axis_tuser_o;  // status[1:0]

  stack_cmd_t   stack_cmds_pending [$];
  stack_reply_t stack_replies_due [$];

  // Shadow copy of the stack contents
  logic [WORD_W-1:0] shadow_words [STACK_DEPTH_DEF];
  int unsigned       shadow_count = 0;

  logic [WORD_W-1:0] value_pool [POOL_SIZE];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned words_sent    = 0;
  int unsigned words_taken   = 0;
  int unsigned error_count   = 0;

  stack_with_delete_by_value_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #5 clk_i = ~clk_i;

  // Apply one command to the shadow stack and return the reply it gives
  function automatic stack_reply_t stack_apply(cmd_e op, logic [WORD_W-1:0] operand);
    stack_reply_t reply;
    int unsigned  pos;
    int unsigned  k;
    reply.value  = '0;
    reply.status = STAT_OK;
    case (op)
      CMD_PUSH: begin
        if (shadow_count >= STACK_DEPTH_DEF) begin
          reply.status = STAT_FULL;
        end else begin
          shadow_words[shadow_count] = operand;
          shadow_count++;
        end
      end
      CMD_POP: begin
        if (shadow_count == 0) begin
          reply.value  = '1;
          reply.status = STAT_EMPTY;
        end else begin
          shadow_count--;
          reply.value = shadow_words[shadow_count];
        end
      end
      CMD_PEEK: begin
        if (shadow_count == 0) begin
          reply.value  = '1;
          reply.status = STAT_EMPTY;
        end else begin
          reply.value = shadow_words[shadow_count-1];
        end
      end
      default: begin
        // Search from the top down, then close the gap over the match
        if (shadow_count == 0) begin
          reply.status = STAT_EMPTY;
        end else begin
          pos = shadow_count;
          while (pos > 0 && shadow_words[pos-1] != operand) pos--;
          if (pos == 0) begin
            reply.status = STAT_NOT_FOUND;
          end else begin
            for (k = pos - 1; k + 1 < shadow_count; k++) shadow_words[k] = shadow_words[k+1];
            shadow_count--;
          end
        end
      end
    endcase
    reply.occ = OCC_W'(shadow_count);
    return reply;
  endfunction

  function automatic void add_cmd(cmd_e op, logic [WORD_W-1:0] operand);
    stack_cmd_t item;
    item.cmd     = op;
    item.operand = operand;
    stack_cmds_pending.push_back(item);
  endfunction

  // Mix push-heavy and drain-heavy stretches so the stack swings between empty and full
  task automatic queue_random_cmds(input int unsigned count);
    int unsigned       left;
    int unsigned       seg_left;
    int unsigned       push_pct;
    int unsigned       roll;
    cmd_e              op;
    logic [WORD_W-1:0] operand;
    left     = count;
    seg_left = 0;
    push_pct = 50;
    while (left > 0) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(40, 10);
        push_pct = $urandom_range(85, 15);
      end
      roll = $urandom_range(99);
      if (roll < push_pct) begin
        op = CMD_PUSH;
      end else begin
        roll = $urandom_range(99);
        op = (roll < 35) ? CMD_POP : (roll < 55) ? CMD_PEEK : CMD_DELETE;
      end
      // Draw mostly from a small pool so deletes hit and duplicates pile up
      if ($urandom_range(99) < 70) operand = value_pool[$urandom_range(POOL_SIZE-1)];
      else operand = $urandom();
      add_cmd(op, operand);
      left--;
      seg_left--;
    end
  endtask

  task automatic wait_drained();
    while (stack_cmds_pending.size() != 0 || words_taken != words_sent ||
           stack_replies_due.size() != 0) @(negedge clk_i);
  endtask

  // Drive command words and the result-side ready at the falling edge
  always @(negedge clk_i) begin
    stack_cmd_t item;
    if (rst_ni) begin
      // Hold a presented word until it is taken
      if (!(s_axis_tvalid_i && words_taken != words_sent)) begin
        if (stack_cmds_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          item = stack_cmds_pending.pop_front();
          s_axis_tdata_i  <= item.operand;
          s_axis_tuser_i  <= item.cmd;
          s_axis_tvalid_i <= 1'b1;
          words_sent++;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Predict on each accepted command word, check each accepted result word
  always @(posedge clk_i) begin
    stack_reply_t exp_reply;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        words_taken++;
        stack_replies_due.push_back(stack_apply(cmd_e'(s_axis_tuser_i), s_axis_tdata_i));
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (stack_replies_due.size() == 0) begin
          $error("unexpected result: result_value %h status %0d occupancy %0d",
                 m_axis_tdata_o[31:0], m_axis_tuser_o, m_axis_tdata_o[36:32]);
          error_count++;
        end else begin
          exp_reply = stack_replies_due.pop_front();
          if (m_axis_tdata_o[31:0] !== exp_reply.value) begin
            $error("result_value expected %h, got %h", exp_reply.value, m_axis_tdata_o[31:0]);
            error_count++;
          end
          if (m_axis_tuser_o !== exp_reply.status) begin
            $error("status expected %0d, got %0d", exp_reply.status, m_axis_tuser_o);
            error_count++;
          end
          if (m_axis_tdata_o[36:32] !== exp_reply.occ) begin
            $error("occupancy expected %0d, got %0d", exp_reply.occ, m_axis_tdata_o[36:32]);
            error_count++;
          end
        end
      end
    end
  end

  // Give up if the run stalls
  initial begin
    #5_000_000;
    $display("tb_stack_with_delete_by_value_core: done, errors");
    $finish;
  end

  initial begin
    int unsigned i;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7fff_ffff;
    value_pool[2] = 32'hffff_ffff;
    value_pool[3] = 32'h0000_0000;
    for (i = 4; i < POOL_SIZE; i++) value_pool[i] = $urandom();

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Phase one: sender rarely idles, receiver stalls often
    send_idle_pct = 7;
    recv_idle_pct = 64;

    // Empty stack on every command that reads it
    add_cmd(CMD_POP, 32'h0000_0000);
    add_cmd(CMD_PEEK, 32'hffff_ffff);
    add_cmd(CMD_DELETE, 32'h0000_0000);
    // Fill to the top, then try one more push
    for (i = 0; i < 16; i++) add_cmd(CMD_PUSH, FILL_WORDS[i]);
    add_cmd(CMD_PUSH, 32'h0bad_cafe);
    // Delete the bottom word (longest shift), then the upper of two duplicates
    add_cmd(CMD_DELETE, 32'h8000_0000);
    add_cmd(CMD_DELETE, 32'h0000_0005);
    // Miss over a full scan, then a match right at the top
    add_cmd(CMD_DELETE, 32'hdead_beef);
    add_cmd(CMD_DELETE, 32'h0000_002a);
    add_cmd(CMD_PEEK, 32'h0000_0000);
    add_cmd(CMD_POP, 32'h0000_0000);

    queue_random_cmds(RAND_CMDS);
    wait_drained();

    // Phase two: sender idles often, receiver rarely stalls
    send_idle_pct = 64;
    recv_idle_pct = 7;
    queue_random_cmds(RAND_CMDS);
    wait_drained();

    // Phase three: full rate on both sides
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_cmds(RAND_CMDS);
    wait_drained();

    repeat (TAIL_WAIT) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_stack_with_delete_by_value_core: done, clean");
    end else begin
      $display("tb_stack_with_delete_by_value_core: done, errors");
    end
    $finish;
  end

endmodule
